// ----- rtl/csat_pkg.sv -----
// Shared constants, codes and control types for the polygon overlap test block.
package csat_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;
  localparam int FIELD_W          = 16;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_A = 2'd0,
    CMD_ADD_B = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Strobes from the sequencer to the projection unit.
  typedef struct packed {
    logic mul_x;
    logic mul_y;
    logic cmp_en;
    logic cmp_first;
    logic cmp_b;
  } proj_ctrl_t;

endpackage

// ----- rtl/csat_if.sv -----
// Request and result channel interfaces of the polygon overlap test block.
interface csat_in_if;
  import csat_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  modport source (output valid, command, vertex_x, vertex_y, input ready);
  modport sink (input valid, command, vertex_x, vertex_y, output ready);
endinterface

interface csat_out_if;
  import csat_pkg::*;
  logic                valid;
  logic                ready;
  logic                overlap;
  logic [STATUS_W-1:0] status;
  modport source (output valid, overlap, status, input ready);
  modport sink (input valid, overlap, status, output ready);
endinterface

// ----- rtl/convex_polygon_sat_overlap_core.sv -----
// Top level: vertex stores and sequencer of the separating-axis polygon overlap test.
// Vertex loads may arrive back to back while no result waits to be taken.
// A test on an empty polygon answers in the cycle after the request; otherwise edges of
// A, then B, pass S_E0 to S_E2 until one separates, and for each normal every vertex of
// both passes S_PRD to S_PCMP on the shared multiplier and single RAM read ports, then S_CHK.
// Reset clears the counts, the overflow flag and the result; the stores are not cleared.
module convex_polygon_sat_overlap_core #(
  parameter int MAX_VERTICES = csat_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = csat_pkg::COORD_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  csat_in_if.sink     in_i,
  csat_out_if.source  out_o
);
  import csat_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int ENT_W = 2 * COORD_BITS;
  localparam int N_W   = COORD_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_E0, S_E1, S_E2, S_PRD, S_PMX, S_PMY, S_PCMP, S_CHK
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                    ovf_q, ovf_d;
  logic                    src_b_q, src_b_d;
  logic                    pb_q, pb_d;
  logic [IDX_W-1:0]        i_q, i_d, k_q, k_d;
  logic signed [COORD_BITS-1:0] p0x_q, p0x_d, p0y_q, p0y_d;
  logic signed [N_W-1:0]   nx_q, nx_d, ny_q, ny_d;
  logic                    out_valid_q, out_valid_d;
  logic                    overlap_q, overlap_d;
  logic [STATUS_W-1:0]     status_q, status_d;

  logic                    in_ready, accept;
  cmd_e                    cmd;
  logic [EXT_W-1:0]        x_ext, y_ext;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic [ENT_W-1:0]        wdata;
  logic                    we_a, we_b;
  logic [IDX_W-1:0]        raddr, j_idx;
  logic [ENT_W-1:0]        rdata_a, rdata_b, rd_ent;
  logic                    rd_sel;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [N_W-1:0]   dx, dy;
  logic [CNT_W-1:0]        n_src, n_cur, i_next, k_next;
  logic                    i_last, k_last;
  logic                    sep;
  proj_ctrl_t              pctrl;
  status_e                 run_status;

  assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept   = in_i.valid && in_ready;
  assign cmd      = cmd_e'(in_i.command);

  assign x_ext = EXT_W'($unsigned(in_i.vertex_x));
  assign y_ext = EXT_W'($unsigned(in_i.vertex_y));
  assign in_x  = x_ext[COORD_BITS-1:0];
  assign in_y  = y_ext[COORD_BITS-1:0];
  assign wdata = {in_y, in_x};

  assign we_a = accept && (cmd == CMD_ADD_A) && (cnt_a_q != CNT_W'(MAX_VERTICES));
  assign we_b = accept && (cmd == CMD_ADD_B) && (cnt_b_q != CNT_W'(MAX_VERTICES));

  assign n_src  = src_b_q ? cnt_b_q : cnt_a_q;
  assign n_cur  = pb_q ? cnt_b_q : cnt_a_q;
  assign i_next = CNT_W'(i_q) + CNT_W'(1);
  assign k_next = CNT_W'(k_q) + CNT_W'(1);
  assign i_last = (i_next == n_src);
  assign k_last = (k_next == n_cur);
  assign j_idx  = i_last ? '0 : i_next[IDX_W-1:0];

  always_comb begin
    case (state_q)
      S_E0:    raddr = i_q;
      S_E1:    raddr = j_idx;
      default: raddr = k_q;
    endcase
  end

  assign rd_sel = ((state_q == S_E1) || (state_q == S_E2)) ? src_b_q : pb_q;
  assign rd_ent = rd_sel ? rdata_b : rdata_a;
  assign rd_x   = rd_ent[COORD_BITS-1:0];
  assign rd_y   = rd_ent[ENT_W-1:COORD_BITS];
  assign dx     = N_W'(rd_x) - N_W'(p0x_q);
  assign dy     = N_W'(rd_y) - N_W'(p0y_q);

  assign pctrl.mul_x     = (state_q == S_PMX);
  assign pctrl.mul_y     = (state_q == S_PMY);
  assign pctrl.cmp_en    = (state_q == S_PCMP);
  assign pctrl.cmp_first = (k_q == '0);
  assign pctrl.cmp_b     = pb_q;

  assign run_status = ovf_q ? ST_DROP : ST_OK;

  csat_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  csat_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  csat_proj #(.COORD_BITS(COORD_BITS)) u_proj (
    .clk_i  (clk_i),
    .ctrl_i (pctrl),
    .rd_x_i (rd_x),
    .rd_y_i (rd_y),
    .nx_i   (nx_q),
    .ny_i   (ny_q),
    .sep_o  (sep)
  );

  always_comb begin
    logic adv_edge;
    logic fin;
    logic fin_overlap;
    status_e fin_status;

    adv_edge    = 1'b0;
    fin         = 1'b0;
    fin_overlap = 1'b0;
    fin_status  = ST_OK;

    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ovf_d       = ovf_q;
    src_b_d     = src_b_q;
    pb_d        = pb_q;
    i_d         = i_q;
    k_d         = k_q;
    p0x_d       = p0x_q;
    p0y_d       = p0y_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    out_valid_d = out_valid_q && !out_o.ready;
    overlap_d   = overlap_q;
    status_d    = status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ADD_A: begin
              if (we_a) cnt_a_d = cnt_a_q + CNT_W'(1);
              else ovf_d = 1'b1;
            end
            CMD_ADD_B: begin
              if (we_b) cnt_b_d = cnt_b_q + CNT_W'(1);
              else ovf_d = 1'b1;
            end
            CMD_TEST: begin
              if (cnt_a_q == '0 || cnt_b_q == '0) begin
                fin         = 1'b1;
                fin_overlap = 1'b0;
                fin_status  = ST_EMPTY;
              end else begin
                src_b_d = 1'b0;
                i_d     = '0;
                state_d = S_E0;
              end
            end
            default: ;
          endcase
        end
      end
      S_E0: state_d = S_E1;
      S_E1: begin
        p0x_d   = rd_x;
        p0y_d   = rd_y;
        state_d = S_E2;
      end
      S_E2: begin
        if (dx == '0 && dy == '0) begin
          adv_edge = 1'b1;
        end else begin
          nx_d    = -dy;
          ny_d    = dx;
          pb_d    = 1'b0;
          k_d     = '0;
          state_d = S_PRD;
        end
      end
      S_PRD:  state_d = S_PMX;
      S_PMX:  state_d = S_PMY;
      S_PMY:  state_d = S_PCMP;
      S_PCMP: begin
        if (!k_last) begin
          k_d     = k_next[IDX_W-1:0];
          state_d = S_PRD;
        end else if (!pb_q) begin
          pb_d    = 1'b1;
          k_d     = '0;
          state_d = S_PRD;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sep) begin
          fin         = 1'b1;
          fin_overlap = 1'b0;
          fin_status  = run_status;
        end else begin
          adv_edge = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv_edge) begin
      if (!i_last) begin
        i_d     = i_next[IDX_W-1:0];
        state_d = S_E0;
      end else if (!src_b_q) begin
        src_b_d = 1'b1;
        i_d     = '0;
        state_d = S_E0;
      end else begin
        fin         = 1'b1;
        fin_overlap = 1'b1;
        fin_status  = run_status;
      end
    end

    if (fin) begin
      out_valid_d = 1'b1;
      overlap_d   = fin_overlap;
      status_d    = fin_status;
      cnt_a_d     = '0;
      cnt_b_d     = '0;
      ovf_d       = 1'b0;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      src_b_q     <= 1'b0;
      pb_q        <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      p0x_q       <= '0;
      p0y_q       <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      out_valid_q <= 1'b0;
      overlap_q   <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      src_b_q     <= src_b_d;
      pb_q        <= pb_d;
      i_q         <= i_d;
      k_q         <= k_d;
      p0x_q       <= p0x_d;
      p0y_q       <= p0y_d;
      nx_q        <= nx_d;
      ny_q        <= ny_d;
      out_valid_q <= out_valid_d;
      overlap_q   <= overlap_d;
      status_q    <= status_d;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.overlap = overlap_q;
  assign out_o.status  = status_q;

endmodule

// ----- rtl/csat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/csat_proj.sv -----
// Shared multiply-accumulate unit that projects vertices and tracks both intervals.
module csat_proj #(
  parameter int COORD_BITS = csat_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  csat_pkg::proj_ctrl_t    ctrl_i,
  input  logic signed [COORD_BITS-1:0] rd_x_i,
  input  logic signed [COORD_BITS-1:0] rd_y_i,
  input  logic signed [COORD_BITS:0]   nx_i,
  input  logic signed [COORD_BITS:0]   ny_i,
  output logic                    sep_o
);
  import csat_pkg::*;

  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int DOT_W  = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] y_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [DOT_W-1:0]      dot_q;
  logic signed [DOT_W-1:0]      a_lo_q, a_hi_q, b_lo_q, b_hi_q;
  logic signed [DOT_W-1:0]      lo_s, hi_s;
  logic signed [COORD_BITS-1:0] mul_a;
  logic signed [COORD_BITS:0]   mul_b;
  logic signed [PROD_W-1:0]     mul_p;

  // One multiplier serves both terms of the dot product.
  assign mul_a = ctrl_i.mul_y ? y_q : rd_x_i;
  assign mul_b = ctrl_i.mul_y ? ny_i : nx_i;
  assign mul_p = PROD_W'(mul_a * mul_b);

  assign lo_s = ctrl_i.cmp_b ? b_lo_q : a_lo_q;
  assign hi_s = ctrl_i.cmp_b ? b_hi_q : a_hi_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_x) begin
      prod_q <= mul_p;
      y_q    <= rd_y_i;
    end
    if (ctrl_i.mul_y) begin
      dot_q <= DOT_W'(prod_q) + DOT_W'(mul_p);
    end
    if (ctrl_i.cmp_en) begin
      if (ctrl_i.cmp_b) begin
        b_lo_q <= (ctrl_i.cmp_first || dot_q < lo_s) ? dot_q : lo_s;
        b_hi_q <= (ctrl_i.cmp_first || dot_q > hi_s) ? dot_q : hi_s;
      end else begin
        a_lo_q <= (ctrl_i.cmp_first || dot_q < lo_s) ? dot_q : lo_s;
        a_hi_q <= (ctrl_i.cmp_first || dot_q > hi_s) ? dot_q : hi_s;
      end
    end
  end

  // Intervals that merely touch count as separated.
  assign sep_o = (a_lo_q >= b_hi_q) || (b_lo_q >= a_hi_q);

endmodule

// ----- tb/csat_overlap_checker.sv -----
// Checker that predicts each polygon overlap result from the accepted requests and compares it.
module csat_overlap_checker (
  input  logic clk_i,
  input  logic rst_ni,
  csat_in_if   req_mon,
  csat_out_if  res_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csat_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;
  localparam int CW   = COORD_BITS_DEF;

  typedef struct {
    logic    overlap;
    status_e status;
  } overlap_result_t;

  longint          a_x [MAXV];
  longint          a_y [MAXV];
  longint          b_x [MAXV];
  longint          b_y [MAXV];
  int unsigned     a_count = 0;
  int unsigned     b_count = 0;
  bit              vertex_dropped = 1'b0;
  int              mismatches = 0;
  overlap_result_t expected_results [$];
  overlap_result_t predicted;
  overlap_result_t expected;

  function automatic longint coord_of_field(input logic [FIELD_W-1:0] raw);
    return longint'($signed(raw[CW-1:0]));
  endfunction

  function automatic void project_span(input bit of_b, input longint nx, input longint ny,
                                       output longint lo, output longint hi);
    int unsigned n;
    int unsigned i;
    longint      d;
    n = of_b ? b_count : a_count;
    for (i = 0; i < n; i++) begin
      d = of_b ? (b_x[i] * nx + b_y[i] * ny) : (a_x[i] * nx + a_y[i] * ny);
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // Skips zero-length edges; touching intervals count as separated.
  function automatic bit has_separating_edge(input bit of_b);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    longint      dx;
    longint      dy;
    longint      a_lo;
    longint      a_hi;
    longint      b_lo;
    longint      b_hi;
    n = of_b ? b_count : a_count;
    for (i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      dx = of_b ? (b_x[j] - b_x[i]) : (a_x[j] - a_x[i]);
      dy = of_b ? (b_y[j] - b_y[i]) : (a_y[j] - a_y[i]);
      if (dx != 0 || dy != 0) begin
        project_span(1'b0, -dy, dx, a_lo, a_hi);
        project_span(1'b1, -dy, dx, b_lo, b_hi);
        if (a_lo >= b_hi || b_lo >= a_hi) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && req_mon.valid && req_mon.ready) begin
      case (cmd_e'(req_mon.command))
        CMD_ADD_A: begin
          if (a_count >= MAXV) begin
            vertex_dropped = 1'b1;
          end else begin
            a_x[a_count] = coord_of_field(req_mon.vertex_x);
            a_y[a_count] = coord_of_field(req_mon.vertex_y);
            a_count++;
          end
        end
        CMD_ADD_B: begin
          if (b_count >= MAXV) begin
            vertex_dropped = 1'b1;
          end else begin
            b_x[b_count] = coord_of_field(req_mon.vertex_x);
            b_y[b_count] = coord_of_field(req_mon.vertex_y);
            b_count++;
          end
        end
        CMD_TEST: begin
          if (a_count == 0 || b_count == 0) begin
            predicted.overlap = 1'b0;
            predicted.status  = ST_EMPTY;
          end else begin
            predicted.overlap = !(has_separating_edge(1'b0) || has_separating_edge(1'b1));
            predicted.status  = vertex_dropped ? ST_DROP : ST_OK;
          end
          expected_results.insert(expected_results.size(), predicted);
          a_count        = 0;
          b_count        = 0;
          vertex_dropped = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (rst_ni && res_mon.valid && res_mon.ready) begin
      if (expected_results.size() == 0) begin
        $error("overlap result with no test pending: overlap %0b, status %0d",
               res_mon.overlap, res_mon.status);
        mismatches++;
      end else begin
        expected = expected_results.pop_front();
        if (res_mon.overlap !== expected.overlap) begin
          $error("overlap mismatch: expected %0b, actual %0b", expected.overlap, res_mon.overlap);
          mismatches++;
        end
        if (res_mon.status !== expected.status) begin
          $error("status mismatch: expected %0d, actual %0d", expected.status, res_mon.status);
          mismatches++;
        end
      end
    end

    pending_o    = expected_results.size();
    fail_count_o = mismatches;
  end

endmodule

// ----- tb/tb_convex_polygon_sat_overlap_core.sv -----
// Testbench top that drives vertex and test requests into the polygon overlap core.
module tb_convex_polygon_sat_overlap_core;
  timeunit 1ns;
  timeprecision 1ps;
  import csat_pkg::*;

  localparam int LIMIT_NS         = 4_000_000;
  localparam int DRAIN_LIMIT      = 200_000;
  localparam int TAIL_CYCLES      = 20;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS      = 150;
  localparam int OCT_X [8] = '{3, 2, 0, -2, -3, -2, 0, 2};
  localparam int OCT_Y [8] = '{0, 2, 3, 2, 0, -2, -3, -2};

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   items_done = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  bit   long_hold_req = 1'b0;

  csat_in_if  req_if ();
  csat_out_if res_if ();

  convex_polygon_sat_overlap_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  csat_overlap_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #LIMIT_NS;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input int x, input int y);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid    <= 1'b0;
      req_if.command  <= CMD_W'($urandom_range(0, 3));
      req_if.vertex_x <= FIELD_W'($urandom);
      req_if.vertex_y <= FIELD_W'($urandom);
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.vertex_x <= FIELD_W'(x);
    req_if.vertex_y <= FIELD_W'(y);
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd != CMD_NONE) items_done++;
  endtask

  function automatic void build_shape(input int n, input int cx, input int cy, input int r,
                                      input bit wild, output int xs[$], output int ys[$]);
    bit [7:0] mask;
    int       rot;
    int       k;
    int       idx;
    xs.delete();
    ys.delete();
    if (n == 0) return;
    if (wild) begin
      for (k = 0; k < n; k++) begin
        xs.insert(xs.size(), int'($urandom_range(0, 65535)) - 32768);
        ys.insert(ys.size(), int'($urandom_range(0, 65535)) - 32768);
      end
      return;
    end
    mask = '0;
    while ($countones(mask) < n) mask[$urandom_range(0, 7)] = 1'b1;
    rot = $urandom_range(0, 7);
    for (k = 0; k < 8; k++) begin
      idx = (k + rot) % 8;
      if (mask[idx]) begin
        xs.insert(xs.size(), cx + OCT_X[idx] * r);
        ys.insert(ys.size(), cy + OCT_Y[idx] * r);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, xs.size() - 1);
      xs.insert(idx, xs[idx]);
      ys.insert(idx, ys[idx]);
    end
  endfunction

  task automatic run_sequence();
    int kind;
    int na;
    int nb;
    int ra;
    int rb;
    int cx;
    int cy;
    int spread;
    bit wild_a;
    bit wild_b;
    int ax [$];
    int ay [$];
    int bx [$];
    int by [$];
    kind   = $urandom_range(0, 99);
    na     = $urandom_range(1, 8);
    nb     = $urandom_range(1, 8);
    ra     = $urandom_range(1, 3000);
    rb     = $urandom_range(1, 3000);
    cx     = int'($urandom_range(0, 40000)) - 20000;
    cy     = int'($urandom_range(0, 40000)) - 20000;
    wild_a = 1'b0;
    wild_b = 1'b0;
    if (kind < 5) begin
      cx = ($urandom_range(0, 1) != 0) ? 30000 : -30000;
      cy = ($urandom_range(0, 1) != 0) ? 30000 : -30000;
    end else if (kind < 12) begin
      case ($urandom_range(0, 2))
        0: na = 0;
        1: nb = 0;
        default: begin
          na = 0;
          nb = 0;
        end
      endcase
    end else if (kind < 18) begin
      if ($urandom_range(0, 1) != 0) begin
        wild_a = 1'b1;
        na     = $urandom_range(17, 20);
      end else begin
        wild_b = 1'b1;
        nb     = $urandom_range(17, 20);
      end
    end
    spread = 3 * (ra + rb) + 1;
    build_shape(na, cx, cy, ra, wild_a, ax, ay);
    build_shape(nb, cx + int'($urandom_range(0, 2 * spread)) - spread,
                cy + int'($urandom_range(0, 2 * spread)) - spread, rb, wild_b, bx, by);
    while (ax.size() + bx.size() > 0) begin
      if ($urandom_range(0, 99) < 6) send_request(CMD_NONE, int'($urandom), int'($urandom));
      if (bx.size() == 0 || (ax.size() != 0 && $urandom_range(0, 1) == 0)) begin
        send_request(CMD_ADD_A, ax.pop_front(), ay.pop_front());
      end else begin
        send_request(CMD_ADD_B, bx.pop_front(), by.pop_front());
      end
    end
    send_request(CMD_TEST, int'($urandom), int'($urandom));
  endtask

  initial begin
    int phase;
    int phase_end;
    int waited;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.command  = CMD_NONE;
    req_if.vertex_x = '0;
    req_if.vertex_y = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(CMD_TEST, 0, 0);
    send_request(CMD_ADD_A, 32767, -32768);
    send_request(CMD_TEST, -1, -1);
    send_request(CMD_NONE, -32768, 32767);
    send_request(CMD_ADD_A, 5, 5);
    send_request(CMD_ADD_B, -7, 9);
    send_request(CMD_TEST, 0, 0);
    send_request(CMD_ADD_A, 0, 0);
    send_request(CMD_ADD_A, 10, 0);
    send_request(CMD_ADD_A, 10, 10);
    send_request(CMD_ADD_A, 0, 10);
    send_request(CMD_ADD_B, 10, 0);
    send_request(CMD_ADD_B, 20, 0);
    send_request(CMD_ADD_B, 20, 10);
    send_request(CMD_ADD_B, 10, 10);
    send_request(CMD_TEST, 0, 0);
    send_request(CMD_ADD_A, -32768, -32768);
    send_request(CMD_ADD_A, 32767, -32768);
    send_request(CMD_ADD_A, 32767, -32768);
    send_request(CMD_ADD_A, 0, 32767);
    send_request(CMD_ADD_B, -1, -1);
    send_request(CMD_ADD_B, 1, -1);
    send_request(CMD_ADD_B, 0, 1);
    send_request(CMD_TEST, 0, 0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          long_hold_req  = 1'b1;
        end
        1: begin
          src_idle_pct   = 68;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 68;
        end
        default: begin
          src_idle_pct   = 22;
          sink_stall_pct = 22;
        end
      endcase
      phase_end = items_done + PHASE_ITEMS;
      while (items_done < phase_end) run_sequence();
    end
    req_if.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
